// ===== rtl/blinn_phong_shade_core_assert.svh =====
// ----------------------------------------------------------------------------
// blinn_phong_shade_core assertion macros
// concurrent checks shared by the shading core
// ----------------------------------------------------------------------------
`ifndef BLINN_PHONG_SHADE_CORE_ASSERT_SVH
`define BLINN_PHONG_SHADE_CORE_ASSERT_SVH

// same-cycle implication
`define BPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define BPS_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// types and constants of the blinn-phong shading core
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } t_request;

    typedef struct packed {
        logic [15:0] intensity;
        logic        degenerate;
    } t_result;

    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_X  = 4'd0,
        CFG_LIGHT_Y  = 4'd1,
        CFG_LIGHT_Z  = 4'd2,
        CFG_CAMERA_X = 4'd3,
        CFG_CAMERA_Y = 4'd4,
        CFG_CAMERA_Z = 4'd5,
        CFG_DIFFUSE  = 4'd6,
        CFG_AMBIENT  = 4'd7
    } t_cfg_idx;

    localparam logic [31:0] RST_LIGHT_X  = 32'd262144;
    localparam logic [31:0] RST_LIGHT_Y  = 32'd65536;
    localparam logic [31:0] RST_LIGHT_Z  = 32'd327680;
    localparam logic [31:0] RST_CAMERA_X = 32'd196608;
    localparam logic [31:0] RST_CAMERA_Y = 32'd0;
    localparam logic [31:0] RST_CAMERA_Z = 32'd0;
    localparam logic [15:0] RST_DIFFUSE  = 16'd3277;
    localparam logic [15:0] RST_AMBIENT  = 16'd410;

    localparam logic [15:0] SPEC_GAIN = 16'd4915;
    localparam int SQ_STEPS   = 5;
    localparam int UNIT_FRAC  = 16;
    localparam int UNIT_W     = 18;
    localparam int COS_W      = 17;
    localparam int TERM_W     = 17;
    localparam int VEC_W      = 33;
    localparam int HV_W       = 19;
    localparam int PROD_W     = 2 * UNIT_W;
    localparam int ROUND_HALF = 32768;
    localparam int UNIT_ONE   = 65536;

    localparam int MAG_W  = 30;
    localparam int SS_W   = 2 * MAG_W + 2;
    localparam int ROOT_W = SS_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int Q_W    = UNIT_FRAC + 1;
    localparam int NUM_W  = MAG_W + UNIT_FRAC + 2;

    localparam int NORM_LAT = 5 + ROOT_W + 1 + Q_W + 1;

endpackage

`default_nettype wire

// ===== rtl/bps_norm.sv =====
// ----------------------------------------------------------------------------
// bps_norm
// pipelined 3-vector normalizer: scale, sum of squares, square root, divide
// ----------------------------------------------------------------------------
`default_nettype none

module bps_norm #(
    parameter int IN_W = 33
) (
    input  logic                                 i_clk,
    input  logic [2:0][IN_W-1:0]                 i_vec,
    output logic [2:0][bps_pkg::UNIT_W-1:0]      o_unit,
    output logic                                 o_zero
);
    import bps_pkg::*;

    localparam int LEAD_W = $clog2(IN_W);
    localparam int EXT_W  = IN_W + MAG_W - 1;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            sgn;
        logic                  zero;
    } t_side;

    // magnitude and sign
    logic [2:0][IN_W-1:0] r_abs;
    logic [2:0]           r_sgn1;
    logic                 r_zero1;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sgn1[i] <= i_vec[i][IN_W-1];
            r_abs[i]  <= i_vec[i][IN_W-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
        end
        r_zero1 <= (i_vec == '0);
    end

    // leading one
    logic [IN_W-1:0]      ored;
    logic [LEAD_W-1:0]    n_lead;
    logic [LEAD_W-1:0]    r_lead;
    logic [2:0][IN_W-1:0] r_abs2;
    logic [2:0]           r_sgn2;
    logic                 r_zero2;

    always_comb begin
        ored   = r_abs[0] | r_abs[1] | r_abs[2];
        n_lead = '0;
        for (int b = 0; b < IN_W; b++) begin
            if (ored[b]) begin
                n_lead = LEAD_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead  <= n_lead;
        r_abs2  <= r_abs;
        r_sgn2  <= r_sgn1;
        r_zero2 <= r_zero1;
    end

    // common shift
    logic [EXT_W-1:0]       ext [3];
    logic [EXT_W-1:0]       shf [3];
    t_side                  r_s3;
    t_side                  r_s4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext[i] = EXT_W'(r_abs2[i]) << (MAG_W - 1);
            shf[i] = ext[i] >> r_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s3.mag[i] <= shf[i][MAG_W-1:0];
        end
        r_s3.sgn  <= r_sgn2;
        r_s3.zero <= r_zero2;
    end

    // squares and sum
    logic [2*MAG_W-1:0] r_sq [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= (2*MAG_W)'(r_s3.mag[i]) * (2*MAG_W)'(r_s3.mag[i]);
        end
        r_s4 <= r_s3;
    end

    logic [SS_W-1:0]   r_rad  [ROOT_W+1];
    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    t_side             r_qs   [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= SS_W'(r_sq[0]) + SS_W'(r_sq[1]) + SS_W'(r_sq[2]);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_qs[0]   <= r_s4;
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        logic             ge;

        always_comb begin
            cur   = {r_rem[k], r_rad[k][SS_W-1 -: 2]};
            trial = (REM_W+2)'({r_root[k], 2'b01});
            ge    = (cur >= trial);
        end

        always_ff @(posedge i_clk) begin
            r_rad[k+1]  <= r_rad[k] << 2;
            r_rem[k+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
            r_root[k+1] <= {r_root[k][ROOT_W-2:0], ge};
            r_qs[k+1]   <= r_qs[k];
        end
    end

    // rounded division, one quotient bit per stage
    logic [2:0][NUM_W-1:0] r_num [Q_W+1];
    logic [2:0][Q_W-1:0]   r_q   [Q_W+1];
    logic [ROOT_W-1:0]     r_den [Q_W+1];
    t_side                 r_ds  [Q_W+1];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_num[0][i] <= (NUM_W'(r_qs[ROOT_W].mag[i]) << UNIT_FRAC)
                         + NUM_W'(r_root[ROOT_W] >> 1);
        end
        r_q[0]   <= '0;
        r_den[0] <= r_root[ROOT_W];
        r_ds[0]  <= r_qs[ROOT_W];
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        logic [NUM_W-1:0]      dsh;
        logic [2:0]            ge;
        logic [2:0][NUM_W-1:0] n_num;
        logic [2:0][Q_W-1:0]   n_q;

        always_comb begin
            dsh = NUM_W'(r_den[j]) << (Q_W - 1 - j);
            for (int i = 0; i < 3; i++) begin
                ge[i]    = (r_num[j][i] >= dsh);
                n_num[i] = ge[i] ? (r_num[j][i] - dsh) : r_num[j][i];
                n_q[i]   = r_q[j][i];
                n_q[i][Q_W-1-j] = ge[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[j+1] <= n_num;
            r_q[j+1]   <= n_q;
            r_den[j+1] <= r_den[j];
            r_ds[j+1]  <= r_ds[j];
        end
    end

    // sign back
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            o_unit[i] <= r_ds[Q_W].sgn[i] ? (~UNIT_W'(r_q[Q_W][i]) + 1'b1)
                                          : UNIT_W'(r_q[Q_W][i]);
        end
        o_zero <= r_ds[Q_W].zero;
    end

endmodule

`default_nettype wire

// ===== rtl/blinn_phong_shade_core.sv =====
// ----------------------------------------------------------------------------
// blinn_phong_shade_core
// per-point blinn-phong lighting, ambient + diffuse + specular (power 32)
// ----------------------------------------------------------------------------
// usage:
//   a request (surface point and normal, signed q16.16) is taken at a rising
//   edge with start high and busy low; busy never rises, so one request per
//   cycle is taken
//   each request yields one result (intensity in unsigned q0.16, degenerate
//   flag) shown for one cycle with o_valid; results leave in request order
//   throughput is one request per cycle; latency is mostly that of the two
//   normalizers in series (square root and divide, one bit per stage each)
//   the user must write configuration registers (light, camera, kd, ka) through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight (unchecked)
//   synchronous reset clears the valid chain and loads the default light,
//   camera and gains; requests in flight at reset are dropped
//   the receiver cannot stall; results are strobed and never held
// ----------------------------------------------------------------------------
`default_nettype none

module blinn_phong_shade_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bps_pkg::t_request              i_req,
    input  logic                           i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_valid,
    output bps_pkg::t_result               o_res
);
    import bps_pkg::*;

    `include "blinn_phong_shade_core_assert.svh"

    localparam int PIPE_LAT = 2 * NORM_LAT + 12;

    typedef struct packed {
        logic [2:0][UNIT_W-1:0] n;
        logic [COS_W-1:0]       cd;
        logic                   ok;
    } t_mid;

    function automatic logic [COS_W-1:0] cos_clamp(
        input logic [2:0][PROD_W-1:0] p
    );
        logic signed [PROD_W+1:0] s;
        logic        [PROD_W+1:0] r;
        s = (PROD_W+2)'($signed(p[0])) + (PROD_W+2)'($signed(p[1]))
          + (PROD_W+2)'($signed(p[2]));
        r = ($unsigned(s) + (PROD_W+2)'(ROUND_HALF)) >> UNIT_FRAC;
        if (s <= 0) begin
            return '0;
        end
        if (r > (PROD_W+2)'(UNIT_ONE)) begin
            return COS_W'(UNIT_ONE);
        end
        return COS_W'(r);
    endfunction

    function automatic logic [COS_W-1:0] sq_round(input logic [COS_W-1:0] c);
        logic [2*COS_W-1:0] p;
        p = (2*COS_W)'(c) * (2*COS_W)'(c) + (2*COS_W)'(ROUND_HALF);
        return COS_W'(p >> UNIT_FRAC);
    endfunction

    function automatic logic [TERM_W-1:0] gain_term(
        input logic [15:0]      g,
        input logic [COS_W-1:0] c
    );
        logic [33:0] p;
        p = 34'(g) * 34'(c) + 34'(ROUND_HALF);
        return TERM_W'(p >> UNIT_FRAC);
    endfunction

    // configuration
    logic signed [31:0] r_light [3];
    logic signed [31:0] r_cam   [3];
    logic [15:0]        r_kd;
    logic [15:0]        r_ka;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light[0] <= RST_LIGHT_X;
            r_light[1] <= RST_LIGHT_Y;
            r_light[2] <= RST_LIGHT_Z;
            r_cam[0]   <= RST_CAMERA_X;
            r_cam[1]   <= RST_CAMERA_Y;
            r_cam[2]   <= RST_CAMERA_Z;
            r_kd       <= RST_DIFFUSE;
            r_ka       <= RST_AMBIENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIGHT_X:  r_light[0] <= i_cfg_data;
                CFG_LIGHT_Y:  r_light[1] <= i_cfg_data;
                CFG_LIGHT_Z:  r_light[2] <= i_cfg_data;
                CFG_CAMERA_X: r_cam[0]   <= i_cfg_data;
                CFG_CAMERA_Y: r_cam[1]   <= i_cfg_data;
                CFG_CAMERA_Z: r_cam[2]   <= i_cfg_data;
                CFG_DIFFUSE:  r_kd       <= i_cfg_data[15:0];
                CFG_AMBIENT:  r_ka       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // request and valid chain
    logic                accept;
    logic [PIPE_LAT-1:0] r_vld;
    t_request            r_req;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= i_req;
    end

    // direction vectors
    logic signed [31:0]    pt [3];
    logic [2:0][VEC_W-1:0] r_nv;
    logic [2:0][VEC_W-1:0] r_lv;
    logic [2:0][VEC_W-1:0] r_vv;

    always_comb begin
        pt[0] = r_req.point_x;
        pt[1] = r_req.point_y;
        pt[2] = r_req.point_z;
    end

    always_ff @(posedge i_clk) begin
        r_nv[0] <= VEC_W'(r_req.normal_x);
        r_nv[1] <= VEC_W'(r_req.normal_y);
        r_nv[2] <= VEC_W'(r_req.normal_z);
        for (int i = 0; i < 3; i++) begin
            r_lv[i] <= VEC_W'(r_light[i]) - VEC_W'(pt[i]);
            r_vv[i] <= VEC_W'(r_cam[i]) - VEC_W'(pt[i]);
        end
    end

    logic [2:0][UNIT_W-1:0] unit_n;
    logic [2:0][UNIT_W-1:0] unit_l;
    logic [2:0][UNIT_W-1:0] unit_v;
    logic [2:0][UNIT_W-1:0] unit_h;
    logic                   zero_n;
    logic                   zero_l;
    logic                   zero_v;
    logic                   zero_h;

    bps_norm #(.IN_W(VEC_W)) u_norm_n (
        .i_clk (i_clk), .i_vec (r_nv), .o_unit (unit_n), .o_zero (zero_n)
    );

    bps_norm #(.IN_W(VEC_W)) u_norm_l (
        .i_clk (i_clk), .i_vec (r_lv), .o_unit (unit_l), .o_zero (zero_l)
    );

    bps_norm #(.IN_W(VEC_W)) u_norm_v (
        .i_clk (i_clk), .i_vec (r_vv), .o_unit (unit_v), .o_zero (zero_v)
    );

    // halfway sum and diffuse products
    logic [2:0][HV_W-1:0]   r_hv;
    logic [2:0][PROD_W-1:0] r_pnl;
    logic [2:0][UNIT_W-1:0] r_nd;
    logic                   r_okd;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_hv[i]  <= HV_W'($signed(unit_l[i])) + HV_W'($signed(unit_v[i]));
            r_pnl[i] <= PROD_W'($signed(unit_n[i]) * $signed(unit_l[i]));
        end
        r_nd  <= unit_n;
        r_okd <= !(zero_n || zero_l || zero_v);
    end

    bps_norm #(.IN_W(HV_W)) u_norm_h (
        .i_clk (i_clk), .i_vec (r_hv), .o_unit (unit_h), .o_zero (zero_h)
    );

    // diffuse cosine, held until the halfway vector is ready
    t_mid r_mid [NORM_LAT];

    always_ff @(posedge i_clk) begin
        r_mid[0] <= '{n: r_nd, cd: cos_clamp(r_pnl), ok: r_okd};
        for (int k = 1; k < NORM_LAT; k++) begin
            r_mid[k] <= r_mid[k-1];
        end
    end

    // specular cosine and power
    logic [2:0][PROD_W-1:0] r_pnh;
    logic [COS_W-1:0]       r_cdg;
    logic                   r_okg;
    logic [COS_W-1:0]       r_cs  [SQ_STEPS+1];
    logic [COS_W-1:0]       r_cds [SQ_STEPS+1];
    logic                   r_oks [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pnh[i] <= PROD_W'($signed(r_mid[NORM_LAT-1].n[i]) * $signed(unit_h[i]));
        end
        r_cdg <= r_mid[NORM_LAT-1].cd;
        r_okg <= r_mid[NORM_LAT-1].ok && !zero_h;

        r_cs[0]  <= cos_clamp(r_pnh);
        r_cds[0] <= r_cdg;
        r_oks[0] <= r_okg;
        for (int k = 0; k < SQ_STEPS; k++) begin
            r_cs[k+1]  <= sq_round(r_cs[k]);
            r_cds[k+1] <= r_cds[k];
            r_oks[k+1] <= r_oks[k];
        end
    end

    // gains and final sum
    logic [TERM_W-1:0] r_td;
    logic [TERM_W-1:0] r_ts;
    logic              r_okt;
    logic [18:0]       sum;

    always_ff @(posedge i_clk) begin
        r_td  <= gain_term(r_kd, r_cds[SQ_STEPS]);
        r_ts  <= gain_term(SPEC_GAIN, r_cs[SQ_STEPS]);
        r_okt <= r_oks[SQ_STEPS];
    end

    assign sum = 19'(r_ka) + 19'(r_td) + 19'(r_ts);

    always_ff @(posedge i_clk) begin
        if (!r_okt) begin
            o_res.intensity <= r_ka;
        end else if (sum > 19'(16'hFFFF)) begin
            o_res.intensity <= 16'hFFFF;
        end else begin
            o_res.intensity <= sum[15:0];
        end
        o_res.degenerate <= !r_okt;
    end

    assign o_valid = r_vld[PIPE_LAT-1];

    `BPS_ASSERT_DLY(a_req_gives_result, i_clk, i_rst_n, accept, PIPE_LAT, o_valid,
        "request did not produce a result")
    `BPS_ASSERT_IMP(a_result_has_request, i_clk, i_rst_n, o_valid,
        $past(accept, PIPE_LAT), "result without a request")
    `BPS_ASSERT_IMP(a_degenerate_ambient, i_clk, i_rst_n, o_valid && o_res.degenerate,
        o_res.intensity == r_ka, "degenerate result is not ambient only")

endmodule

`default_nettype wire

// ===== tb/tb_blinn_phong_shade_core.sv =====
// ----------------------------------------------------------------------------
// tb_blinn_phong_shade_core
// self-checking bench for the shading core: a bit-exact predictor of the
// fixed-point lighting math scores every strobed result against the requests
// taken, over several light, camera and gain settings with random gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_blinn_phong_shade_core;
    import bps_pkg::*;

    class shade_scoreboard;
        logic [31:0] lgt [3];
        logic [31:0] cam [3];
        logic [15:0] kd;
        logic [15:0] ka;
        t_result pending [$];
        int errors;

        function new();
            lgt[0] = RST_LIGHT_X; lgt[1] = RST_LIGHT_Y; lgt[2] = RST_LIGHT_Z;
            cam[0] = RST_CAMERA_X; cam[1] = RST_CAMERA_Y; cam[2] = RST_CAMERA_Z;
            kd = RST_DIFFUSE;
            ka = RST_AMBIENT;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_LIGHT_X:  lgt[0] = val;
                CFG_LIGHT_Y:  lgt[1] = val;
                CFG_LIGHT_Z:  lgt[2] = val;
                CFG_CAMERA_X: cam[0] = val;
                CFG_CAMERA_Y: cam[1] = val;
                CFG_CAMERA_Z: cam[2] = val;
                CFG_DIFFUSE:  kd = val[15:0];
                CFG_AMBIENT:  ka = val[15:0];
                default: ;
            endcase
        endfunction

        function automatic logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] res, bits;
            res = 0;
            bits = 64'd1 << 62;
            while (bits > v) bits = bits >> 2;
            while (bits != 0) begin
                if (v >= res + bits) begin
                    v = v - (res + bits);
                    res = (res >> 1) + bits;
                end else begin
                    res = res >> 1;
                end
                bits = bits >> 2;
            end
            return res;
        endfunction

        function automatic bit unit_vec(input longint v [3], output longint u [3]);
            logic [63:0] m [3];
            logic [63:0] mx, ss, r, q;
            mx = 0;
            ss = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (v[i] < 0) ? -v[i] : v[i];
                if (m[i] > mx) mx = m[i];
            end
            if (mx == 0) return 0;
            while (mx >= (64'd1 << 30)) begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (mx < (64'd1 << 29)) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            for (int i = 0; i < 3; i++) ss = ss + m[i] * m[i];
            r = root_floor(ss);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << 16) + (r >> 1)) / r;
                if (q > UNIT_ONE) q = UNIT_ONE;
                u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function automatic logic [63:0] clamp_cos(longint a [3], longint b [3]);
            longint d;
            logic [63:0] c;
            d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            if (d <= 0) return 0;
            c = (d + 32768) >> 16;
            return (c > UNIT_ONE) ? UNIT_ONE : c;
        endfunction

        function void note_request(t_request rq);
            longint p [3], nv [3], lv [3], vv [3], hv [3];
            longint n [3], l [3], v [3], h [3];
            logic [63:0] cd, cs, sum;
            bit ok;
            t_result e;
            p[0] = rq.point_x; p[1] = rq.point_y; p[2] = rq.point_z;
            nv[0] = rq.normal_x; nv[1] = rq.normal_y; nv[2] = rq.normal_z;
            for (int i = 0; i < 3; i++) begin
                lv[i] = longint'($signed(lgt[i])) - p[i];
                vv[i] = longint'($signed(cam[i])) - p[i];
            end
            ok = unit_vec(nv, n);
            ok = unit_vec(lv, l) && ok;
            ok = unit_vec(vv, v) && ok;
            if (ok) begin
                for (int i = 0; i < 3; i++) hv[i] = l[i] + v[i];
                ok = unit_vec(hv, h);
            end
            if (!ok) begin
                e.intensity = ka;
                e.degenerate = 1'b1;
            end else begin
                cd = clamp_cos(n, l);
                cs = clamp_cos(n, h);
                for (int i = 0; i < SQ_STEPS; i++) cs = (cs * cs + 32768) >> 16;
                sum = ka;
                sum = sum + ((kd * cd + 32768) >> 16);
                sum = sum + ((SPEC_GAIN * cs + 32768) >> 16);
                if (sum > 65535) sum = 65535;
                e.intensity = sum[15:0];
                e.degenerate = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h/%b",
                         $time, got.intensity, got.degenerate);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.intensity !== e.intensity) begin
                $display("%0t intensity mismatch: expected %h, actual %h",
                         $time, e.intensity, got.intensity);
                errors++;
            end
            if (got.degenerate !== e.degenerate) begin
                $display("%0t degenerate mismatch: expected %b, actual %b",
                         $time, e.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 2 * NORM_LAT + 12;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_request i_req = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_valid;
    t_result o_res;

    shade_scoreboard sb;
    bit quiet_tail = 0;

    blinn_phong_shade_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_res(o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_res);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'($signed($urandom_range(0, 16'hffff)) - 32768) << 8;
            default: return 32'($signed($urandom_range(0, 24'hff_ffff)) - 24'h80_0000);
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic send(t_request rq);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        start = 1'b1;
        i_req = rq;
        do @(posedge i_clk); while (busy);
        sb.note_request(rq);
        @(negedge i_clk);
    endtask

    task automatic idle_start();
        start = 1'b0;
        @(negedge i_clk);
    endtask

    function automatic t_request rand_req(bit mostly_sane);
        t_request rq;
        rq.point_x = rand_coord(); rq.point_y = rand_coord(); rq.point_z = rand_coord();
        rq.normal_x = rand_coord(); rq.normal_y = rand_coord(); rq.normal_z = rand_coord();
        if (mostly_sane && $urandom_range(0, 2) != 0) begin
            rq.point_x = 32'($signed($urandom_range(0, 20'hfffff)) - 20'h80000);
            rq.point_y = 32'($signed($urandom_range(0, 20'hfffff)) - 20'h80000);
            rq.point_z = 32'($signed($urandom_range(0, 20'hfffff)) - 20'h80000);
        end
        case ($urandom_range(0, 29))
            0: begin rq.normal_x = 0; rq.normal_y = 0; rq.normal_z = 0; end
            1: begin
                rq.point_x = sb.lgt[0]; rq.point_y = sb.lgt[1]; rq.point_z = sb.lgt[2];
            end
            2: begin
                rq.point_x = sb.cam[0]; rq.point_y = sb.cam[1]; rq.point_z = sb.cam[2];
            end
            default: ;
        endcase
        return rq;
    endfunction

    initial begin
        t_request rq;
        logic [31:0] vals [6];
        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: axis normals, extremes, each degenerate case
        rq = '0;
        rq.normal_z = 32'h0001_0000;
        send(rq);
        rq.normal_z = 32'hffff_0000;
        send(rq);
        rq.normal_x = 32'h7fff_ffff; rq.normal_y = 32'h7fff_ffff; rq.normal_z = 32'h7fff_ffff;
        send(rq);
        rq.normal_x = 32'h8000_0000; rq.normal_y = 32'h8000_0000; rq.normal_z = 32'h8000_0000;
        send(rq);
        rq.normal_x = 32'd1; rq.normal_y = 0; rq.normal_z = 0;
        send(rq);
        rq.normal_x = 0;
        send(rq);
        rq = '0; rq.normal_y = 32'h0001_0000;
        rq.point_x = RST_LIGHT_X; rq.point_y = RST_LIGHT_Y; rq.point_z = RST_LIGHT_Z;
        send(rq);
        rq.point_x = RST_CAMERA_X; rq.point_y = RST_CAMERA_Y; rq.point_z = RST_CAMERA_Z;
        send(rq);
        rq.point_x = 32'h8000_0000; rq.point_y = 32'h7fff_ffff; rq.point_z = 32'h8000_0000;
        send(rq);
        // midpoint of light and camera: opposite directions, L + V zero
        rq.point_x = 32'h0003_8000; rq.point_y = 32'h0000_8000; rq.point_z = 32'h0002_8000;
        send(rq);
        idle_start();
        drain();

        write_reg(CFG_LIGHT_X, 32'h0001_0000);
        write_reg(CFG_LIGHT_Y, 32'h0001_0000);
        write_reg(CFG_LIGHT_Z, 32'h0001_0000);
        write_reg(CFG_CAMERA_X, 32'h0001_0000);
        write_reg(CFG_CAMERA_Y, 32'h0001_0000);
        write_reg(CFG_CAMERA_Z, 32'h0001_0000);
        write_reg(CFG_DIFFUSE, 32'h0000_ffff);
        write_reg(CFG_AMBIENT, 32'h0000_ffff);
        rq = '0; rq.normal_x = 32'h0001_0000; rq.normal_y = 32'h0001_0000;
        rq.normal_z = 32'h0001_0000;
        send(rq);
        idle_start();
        drain();
        write_reg(CFG_AMBIENT, 32'h0000_8000);
        send(rq);
        idle_start();
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    vals = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
                    write_reg(CFG_DIFFUSE, 32'h0);
                    write_reg(CFG_AMBIENT, 32'h0);
                end
                1: begin
                    vals = '{RST_LIGHT_X, RST_LIGHT_Y, RST_LIGHT_Z,
                             RST_CAMERA_X, RST_CAMERA_Y, RST_CAMERA_Z};
                    write_reg(CFG_DIFFUSE, RST_DIFFUSE);
                    write_reg(CFG_AMBIENT, RST_AMBIENT);
                end
                default: begin
                    for (int i = 0; i < 6; i++) vals[i] = rand_coord();
                    write_reg(CFG_DIFFUSE, $urandom());
                    write_reg(CFG_AMBIENT, $urandom());
                end
            endcase
            for (int i = 0; i < 6; i++) write_reg(t_cfg_idx'(i), vals[i]);
            if (phase == 5) quiet_tail = 1;
            for (int k = 0; k < 300; k++) send(rand_req(1));
            idle_start();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
